[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL of the segment intersection unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define SIP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked outside reset
`define SIP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/core/sip_pkg.sv]
// Shared constants and types of the segment intersection unit
package sip_pkg;

  localparam int PARAM_FRAC_BITS_DEF = 16;
  localparam int COORD_W = 24;
  localparam int DIFF_W  = 25;
  localparam int PROD_W  = 50;
  localparam int CROSS_W = 51;
  localparam int OUT_W   = 18;
  localparam int LIMIT_W = 32;
  localparam int TOL_W   = 8;

  localparam logic [LIMIT_W-1:0] LIMIT_RST = 32'd1;
  localparam logic [TOL_W-1:0]   TOL_RST   = 8'd1;

  // Register indexes (byte address bit 2)
  localparam logic REG_LIMIT = 1'b0;
  localparam logic REG_TOL   = 1'b1;

  // Control flags that travel with one transaction down the divider chain
  typedef struct packed {
    logic ok;
    logic neg_t;
    logic neg_u;
    logic sat_t;
    logic sat_u;
  } ctl_t;

endpackage

[rtl/core/segment_intersection_param_unit.sv]
// Top level of the segment intersection unit: handshake, registers, divider chain, result stage
// Takes one segment pair per cycle while the output is not held back, and returns one result
// per pair, in order, through five front stages (edge vectors, products, cross products,
// magnitudes, integer quotient bit), one divider cell per fraction bit, and the output
// register. Every stage holds its own ready, so an item is taken whenever any stage ahead
// has room, also while a result waits at the output. hit travels on out_tuser; out_tdata
// carries t, or -1.0 on a miss. No memories, no clearing pass after reset.
`include "assert_macros.svh"

module segment_intersection_param_unit #(
  parameter int PARAM_FRAC_BITS = sip_pkg::PARAM_FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // p_start_x, p_start_y, p_end_x, p_end_y, q_start_x, q_start_y, q_end_x, q_end_y
  input  logic [191:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // param_along_p [17:0], zero fill [23:18]
  output logic [23:0]  out_tdata,
  // hit
  output logic         out_tuser,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  localparam int F  = PARAM_FRAC_BITS;
  localparam int QW = F + 1;
  localparam int TW = F + 2;
  localparam int BW = TW + 1;
  localparam int NS = F + 6;
  localparam int OW = sip_pkg::OUT_W;
  localparam int CW = sip_pkg::CROSS_W;
  localparam int KW = sip_pkg::COORD_W;

  logic [sip_pkg::LIMIT_W-1:0] limit_r;
  logic [sip_pkg::TOL_W-1:0]   tol_r;
  logic                        wr_en;
  logic [NS-1:0]               v_r;
  logic [NS-1:0]               ld;

  sip_pkg::ctl_t   ctl_c [F+1];
  logic [CW-1:0]   ad_c  [F+1];
  logic [CW-1:0]   rt_c  [F+1];
  logic [CW-1:0]   ru_c  [F+1];
  logic [QW-1:0]   qt_c  [F+1];
  logic [QW-1:0]   qu_c  [F+1];

  logic signed [TW-1:0] st, su;
  logic [TW+OW-1:0]     t_ext, one_w, miss_w;
  logic                 hit_nxt;
  logic [OW-1:0]        t_nxt;
  logic                 hit_r;
  logic [OW-1:0]        t_r;

  // Configuration registers
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= sip_pkg::LIMIT_RST;
      tol_r   <= sip_pkg::TOL_RST;
    end else if (wr_en) begin
      case (cfg_paddr[2])
        sip_pkg::REG_LIMIT: limit_r <= cfg_pwdata;
        sip_pkg::REG_TOL:   tol_r   <= cfg_pwdata[sip_pkg::TOL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      sip_pkg::REG_LIMIT: cfg_prdata = limit_r;
      sip_pkg::REG_TOL:   cfg_prdata = 32'(tol_r);
      default:            cfg_prdata = '0;
    endcase
  end

  // Per-stage load: a stage advances when empty or when its successor advances
  always_comb begin
    ld[NS-1] = !v_r[NS-1] || out_tready;
    for (int i = NS - 2; i >= 0; i--) begin
      ld[i] = !v_r[i] || ld[i+1];
    end
  end

  assign in_tready  = ld[0];
  assign out_tvalid = v_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int i = 0; i < NS; i++) begin
        if (ld[i]) begin
          v_r[i] <= (i == 0) ? in_tvalid : v_r[(i == 0) ? 0 : i - 1];
        end
      end
    end
  end

  // Front stages
  sip_front #(.QW(QW)) u_front (
    .clk       (clk),
    .ld        (ld[4:0]),
    .p_start_x ($signed(in_tdata[0*KW +: KW])),
    .p_start_y ($signed(in_tdata[1*KW +: KW])),
    .p_end_x   ($signed(in_tdata[2*KW +: KW])),
    .p_end_y   ($signed(in_tdata[3*KW +: KW])),
    .q_start_x ($signed(in_tdata[4*KW +: KW])),
    .q_start_y ($signed(in_tdata[5*KW +: KW])),
    .q_end_x   ($signed(in_tdata[6*KW +: KW])),
    .q_end_y   ($signed(in_tdata[7*KW +: KW])),
    .limit     (limit_r),
    .ctl_o     (ctl_c[0]),
    .ad_o      (ad_c[0]),
    .rt_o      (rt_c[0]),
    .ru_o      (ru_c[0]),
    .qt_o      (qt_c[0]),
    .qu_o      (qu_c[0])
  );

  // Divider chain, one fraction bit per cell
  for (genvar g = 0; g < F; g++) begin : g_cell
    sip_div_cell #(.QW(QW)) u_cell (
      .clk   (clk),
      .ld    (ld[5+g]),
      .ctl_i (ctl_c[g]),
      .ad_i  (ad_c[g]),
      .rt_i  (rt_c[g]),
      .ru_i  (ru_c[g]),
      .qt_i  (qt_c[g]),
      .qu_i  (qu_c[g]),
      .ctl_o (ctl_c[g+1]),
      .ad_o  (ad_c[g+1]),
      .rt_o  (rt_c[g+1]),
      .ru_o  (ru_c[g+1]),
      .qt_o  (qt_c[g+1]),
      .qu_o  (qu_c[g+1])
    );
  end

  // Check a quotient against [-tol, 1 + tol]
  function automatic logic in_bounds(input logic signed [TW-1:0] val,
                                     input logic [sip_pkg::TOL_W-1:0] tol);
    logic signed [BW-1:0] vw, lo, hi;
    vw = BW'(val);
    lo = -$signed(BW'(tol));
    hi = $signed(BW'(1) << F) + $signed(BW'(tol));
    return (vw >= lo) && (vw <= hi);
  endfunction

  // Apply signs, test bounds, pick t or the miss value
  always_comb begin
    st      = ctl_c[F].neg_t ? -$signed({1'b0, qt_c[F]}) : $signed({1'b0, qt_c[F]});
    su      = ctl_c[F].neg_u ? -$signed({1'b0, qu_c[F]}) : $signed({1'b0, qu_c[F]});
    t_ext   = {{OW{st[TW-1]}}, st};
    one_w   = (TW + OW)'(1) << F;
    miss_w  = '0 - one_w;
    hit_nxt = ctl_c[F].ok && !ctl_c[F].sat_t && !ctl_c[F].sat_u &&
              in_bounds(st, tol_r) && in_bounds(su, tol_r);
    t_nxt   = hit_nxt ? t_ext[OW-1:0] : miss_w[OW-1:0];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (ld[NS-1]) begin
      hit_r <= hit_nxt;
      t_r   <= t_nxt;
    end
  end

  assign out_tuser = hit_r;
  assign out_tdata = {6'b0, t_r};

  `SIP_ASSERT_IMPL(a_miss_value, clk, rst_n, out_tvalid && !out_tuser, out_tdata[OW-1:0] == miss_w[OW-1:0])
  `SIP_ASSERT_NEXT(a_accept_fills, clk, rst_n, in_tvalid && in_tready, v_r[0])
  `SIP_ASSERT_NEXT(a_stall_keeps, clk, rst_n, v_r[0] && !ld[0], v_r[0])

endmodule

[rtl/core/sip_front.sv]
// Front stages: differences, products, cross products, magnitudes, integer quotient step
module sip_front #(
  parameter int QW = sip_pkg::PARAM_FRAC_BITS_DEF + 1
) (
  input  logic                             clk,
  input  logic [4:0]                       ld,
  input  logic signed [sip_pkg::COORD_W-1:0] p_start_x,
  input  logic signed [sip_pkg::COORD_W-1:0] p_start_y,
  input  logic signed [sip_pkg::COORD_W-1:0] p_end_x,
  input  logic signed [sip_pkg::COORD_W-1:0] p_end_y,
  input  logic signed [sip_pkg::COORD_W-1:0] q_start_x,
  input  logic signed [sip_pkg::COORD_W-1:0] q_start_y,
  input  logic signed [sip_pkg::COORD_W-1:0] q_end_x,
  input  logic signed [sip_pkg::COORD_W-1:0] q_end_y,
  input  logic [sip_pkg::LIMIT_W-1:0]      limit,
  output sip_pkg::ctl_t                    ctl_o,
  output logic [sip_pkg::CROSS_W-1:0]      ad_o,
  output logic [sip_pkg::CROSS_W-1:0]      rt_o,
  output logic [sip_pkg::CROSS_W-1:0]      ru_o,
  output logic [QW-1:0]                    qt_o,
  output logic [QW-1:0]                    qu_o
);

  localparam int DW = sip_pkg::DIFF_W;
  localparam int PW = sip_pkg::PROD_W;
  localparam int CW = sip_pkg::CROSS_W;

  logic signed [DW-1:0] rx_r, ry_r, sx_r, sy_r, cx_r, cy_r;
  logic signed [PW-1:0] m_rsy_r, m_rys_r, m_csy_r, m_cys_r, m_cry_r, m_cyr_r;
  logic signed [CW-1:0] rxs_r, nt_r, nu_r;
  logic [CW-1:0]        ad_r, ant_r, anu_r;
  logic                 ok_r, negt_r, negu_r;
  logic [CW-1:0]        mag_d, mag_t, mag_u;
  logic                 sat_t, sat_u, ip_t, ip_u;

  // Form the edge vectors
  always_ff @(posedge clk) begin
    if (ld[0]) begin
      rx_r <= DW'(p_end_x) - DW'(p_start_x);
      ry_r <= DW'(p_end_y) - DW'(p_start_y);
      sx_r <= DW'(q_end_x) - DW'(q_start_x);
      sy_r <= DW'(q_end_y) - DW'(q_start_y);
      cx_r <= DW'(q_start_x) - DW'(p_start_x);
      cy_r <= DW'(q_start_y) - DW'(p_start_y);
    end
  end

  // Register the six partial products
  always_ff @(posedge clk) begin
    if (ld[1]) begin
      m_rsy_r <= rx_r * sy_r;
      m_rys_r <= ry_r * sx_r;
      m_csy_r <= cx_r * sy_r;
      m_cys_r <= cy_r * sx_r;
      m_cry_r <= cx_r * ry_r;
      m_cyr_r <= cy_r * rx_r;
    end
  end

  // Combine into the three cross products
  always_ff @(posedge clk) begin
    if (ld[2]) begin
      rxs_r <= CW'(m_rsy_r) - CW'(m_rys_r);
      nt_r  <= CW'(m_csy_r) - CW'(m_cys_r);
      nu_r  <= CW'(m_cry_r) - CW'(m_cyr_r);
    end
  end

  // Take magnitudes and signs, test against the parallel limit
  always_comb begin
    mag_d = rxs_r[CW-1] ? CW'(-rxs_r) : CW'(rxs_r);
    mag_t = nt_r[CW-1]  ? CW'(-nt_r)  : CW'(nt_r);
    mag_u = nu_r[CW-1]  ? CW'(-nu_r)  : CW'(nu_r);
  end

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      ad_r   <= mag_d;
      ant_r  <= mag_t;
      anu_r  <= mag_u;
      ok_r   <= (rxs_r != '0) && (mag_d >= CW'(limit));
      negt_r <= nt_r[CW-1] ^ rxs_r[CW-1];
      negu_r <= nu_r[CW-1] ^ rxs_r[CW-1];
    end
  end

  // Integer part of each quotient: saturate at two, else one bit
  always_comb begin
    sat_t = {1'b0, ant_r} >= {ad_r, 1'b0};
    sat_u = {1'b0, anu_r} >= {ad_r, 1'b0};
    ip_t  = ant_r >= ad_r;
    ip_u  = anu_r >= ad_r;
  end

  always_ff @(posedge clk) begin
    if (ld[4]) begin
      ctl_o <= '{ok: ok_r, neg_t: negt_r, neg_u: negu_r, sat_t: sat_t, sat_u: sat_u};
      ad_o  <= ad_r;
      rt_o  <= ip_t ? ant_r - ad_r : ant_r;
      ru_o  <= ip_u ? anu_r - ad_r : anu_r;
      qt_o  <= QW'(ip_t);
      qu_o  <= QW'(ip_u);
    end
  end

endmodule

[rtl/core/sip_div_cell.sv]
// One restoring divider cell: one fraction bit of both quotients per stage
module sip_div_cell #(
  parameter int QW = sip_pkg::PARAM_FRAC_BITS_DEF + 1
) (
  input  logic                        clk,
  input  logic                        ld,
  input  sip_pkg::ctl_t               ctl_i,
  input  logic [sip_pkg::CROSS_W-1:0] ad_i,
  input  logic [sip_pkg::CROSS_W-1:0] rt_i,
  input  logic [sip_pkg::CROSS_W-1:0] ru_i,
  input  logic [QW-1:0]               qt_i,
  input  logic [QW-1:0]               qu_i,
  output sip_pkg::ctl_t               ctl_o,
  output logic [sip_pkg::CROSS_W-1:0] ad_o,
  output logic [sip_pkg::CROSS_W-1:0] rt_o,
  output logic [sip_pkg::CROSS_W-1:0] ru_o,
  output logic [QW-1:0]               qt_o,
  output logic [QW-1:0]               qu_o
);

  localparam int CW = sip_pkg::CROSS_W;

  logic [CW:0] dt, du, trial_t, trial_u;
  logic        bt, bu;

  // Double the remainder and try a subtraction of the divisor
  always_comb begin
    dt      = {rt_i, 1'b0};
    du      = {ru_i, 1'b0};
    trial_t = dt - {1'b0, ad_i};
    trial_u = du - {1'b0, ad_i};
    bt      = dt >= {1'b0, ad_i};
    bu      = du >= {1'b0, ad_i};
  end

  // Hand the partial result to the next cell
  always_ff @(posedge clk) begin
    if (ld) begin
      ctl_o <= ctl_i;
      ad_o  <= ad_i;
      rt_o  <= bt ? trial_t[CW-1:0] : dt[CW-1:0];
      ru_o  <= bu ? trial_u[CW-1:0] : du[CW-1:0];
      qt_o  <= {qt_i[QW-2:0], bt};
      qu_o  <= {qu_i[QW-2:0], bu};
    end
  end

endmodule
